// ----- hdl/s2d_pkg.sv -----
// shared types and constants for the signed integer to decimal ascii converter
// no dependencies; used by s2d_digit_cell and signed_int_to_decimal_ascii
`default_nettype none

package s2d_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned NumDigits  = 19;
  localparam int unsigned DigitWidth = 4;
  localparam int unsigned CharWidth  = 6;
  localparam int unsigned BitCntW    = $clog2(ValueWidth);
  localparam int unsigned DigCntW    = $clog2(NumDigits + 1);

  localparam logic [CharWidth-1:0] CharZero  = 6'd48;
  localparam logic [CharWidth-1:0] CharMinus = 6'd45;

  // command broadcast to every digit cell
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_CLEAR,
    CMD_DABBLE,
    CMD_SHIFT
  } cell_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_SKIP,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

// ----- hdl/s2d_digit_cell.sv -----
// one bcd digit of the double-dabble chain: add-3 correction and shift,
// or a whole-digit shift toward the top for output; depends on s2d_pkg
`default_nettype none

module s2d_digit_cell (
  input  wire                             clk_i,
  input  s2d_pkg::cell_cmd_e              cmd_i,
  input  wire                             carry_i,
  input  wire  [s2d_pkg::DigitWidth-1:0]  digit_i,
  output logic                            carry_o,
  output logic [s2d_pkg::DigitWidth-1:0]  digit_o
);

  logic [s2d_pkg::DigitWidth-1:0] digit_q;
  logic [s2d_pkg::DigitWidth-1:0] digit_d;
  logic [s2d_pkg::DigitWidth-1:0] adj;

  // digits of five or more get three added before the doubling
  assign adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
  assign carry_o = adj[s2d_pkg::DigitWidth-1];
  assign digit_o = digit_q;

  always_comb begin
    unique case (cmd_i)
      s2d_pkg::CMD_HOLD:   digit_d = digit_q;
      s2d_pkg::CMD_CLEAR:  digit_d = '0;
      s2d_pkg::CMD_DABBLE: digit_d = {adj[s2d_pkg::DigitWidth-2:0], carry_i};
      s2d_pkg::CMD_SHIFT:  digit_d = digit_i;
      default:             digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

`default_nettype wire

// ----- hdl/signed_int_to_decimal_ascii.sv -----
// Converts one signed 64-bit integer per transaction into its decimal ASCII text,
// most significant character first, with a leading '-' for negative values and
// tlast on the final character. The magnitude is fed one bit per cycle into a
// row of 19 BCD digit cells (double dabble); after the sign step the digits shift
// up one cell per cycle, leading zeros dropped and the rest sent out, the sending
// held while the output register is full and not taken. The next value is taken
// while the last character may still wait in the output register. Depends on
// s2d_pkg and s2d_digit_cell.
`default_nettype none

module signed_int_to_decimal_ascii (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,   // [63:0] value (signed)
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [5:0] char_code, [7:6] zero
  output logic        m_axis_tlast    // last
);

  localparam int unsigned ND = s2d_pkg::NumDigits;
  localparam int unsigned DW = s2d_pkg::DigitWidth;

  s2d_pkg::state_e    state_q, state_d;
  s2d_pkg::cell_cmd_e cmd;

  logic [s2d_pkg::ValueWidth-1:0] mag_q, mag_d;
  logic                           neg_q, neg_d;
  logic [s2d_pkg::BitCntW-1:0]    bit_cnt_q, bit_cnt_d;
  logic [s2d_pkg::DigCntW-1:0]    rem_q, rem_d;

  logic                           out_valid_q;
  logic [s2d_pkg::CharWidth-1:0]  out_char_q;
  logic                           out_last_q;
  logic                           emit;
  logic [s2d_pkg::CharWidth-1:0]  emit_char;
  logic                           emit_last;
  logic                           slot_free;

  logic [ND-1:0]   carry;
  logic [DW-1:0]   digit [ND];
  logic [DW-1:0]   top_digit;

  assign slot_free = !out_valid_q || m_axis_tready;
  assign top_digit = digit[ND-1];

  // digit cell row, least significant digit at index 0
  for (genvar k = 0; k < ND; k++) begin : g_cell
    logic          cin;
    logic [DW-1:0] din;
    if (k == 0) begin : g_first
      assign cin = mag_q[s2d_pkg::ValueWidth-1];
      assign din = '0;
    end else begin : g_rest
      assign cin = carry[k-1];
      assign din = digit[k-1];
    end
    s2d_digit_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .carry_i (cin),
      .digit_i (din),
      .carry_o (carry[k]),
      .digit_o (digit[k])
    );
  end

  always_comb begin
    state_d       = state_q;
    mag_d         = mag_q;
    neg_d         = neg_q;
    bit_cnt_d     = bit_cnt_q;
    rem_d         = rem_q;
    cmd           = s2d_pkg::CMD_HOLD;
    s_axis_tready = 1'b0;
    emit          = 1'b0;
    emit_char     = s2d_pkg::CharZero + {2'b00, top_digit};
    emit_last     = 1'b0;

    unique case (state_q)
      s2d_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          neg_d     = s_axis_tdata[s2d_pkg::ValueWidth-1];
          mag_d     = neg_d ? (~s_axis_tdata + 64'd1) : s_axis_tdata;
          bit_cnt_d = '0;
          rem_d     = s2d_pkg::DigCntW'(ND);
          cmd       = s2d_pkg::CMD_CLEAR;
          state_d   = s2d_pkg::ST_CONV;
        end
      end
      s2d_pkg::ST_CONV: begin
        cmd       = s2d_pkg::CMD_DABBLE;
        mag_d     = {mag_q[s2d_pkg::ValueWidth-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + 1'b1;
        if (bit_cnt_q == s2d_pkg::BitCntW'(s2d_pkg::ValueWidth - 1)) begin
          state_d = s2d_pkg::ST_SIGN;
        end
      end
      s2d_pkg::ST_SIGN: begin
        if (!neg_q) begin
          state_d = s2d_pkg::ST_SKIP;
        end else if (slot_free) begin
          emit      = 1'b1;
          emit_char = s2d_pkg::CharMinus;
          state_d   = s2d_pkg::ST_SKIP;
        end
      end
      s2d_pkg::ST_SKIP: begin
        // drop leading zeros, but always keep the units digit
        if (top_digit == '0 && rem_q != s2d_pkg::DigCntW'(1)) begin
          cmd   = s2d_pkg::CMD_SHIFT;
          rem_d = rem_q - 1'b1;
        end else begin
          state_d = s2d_pkg::ST_EMIT;
        end
      end
      s2d_pkg::ST_EMIT: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_last = (rem_q == s2d_pkg::DigCntW'(1));
          cmd       = s2d_pkg::CMD_SHIFT;
          rem_d     = rem_q - 1'b1;
          if (emit_last) begin
            state_d = s2d_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = s2d_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= s2d_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q     <= mag_d;
    neg_q     <= neg_d;
    bit_cnt_q <= bit_cnt_d;
    rem_q     <= rem_d;
    if (emit) begin
      out_char_q <= emit_char;
      out_last_q <= emit_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_char_q};
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire
